// ===== hdl/sukx_pkg.sv =====
`timescale 1ns / 1ps
package sukx_pkg;

    localparam int TABLE_SLOTS = 2048;
    localparam int MAX_ROWS    = 1024;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int ROW_W   = 10;
    localparam int EPOCH_W = 8;
    localparam int NCHUNK  = (64 + SLOT_W - 1) / SLOT_W;

    typedef enum logic [1:0] {
        ST_SEEN = 2'd0,
        ST_NEW  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [63:0]        value;
        logic [63:0]        time_stamp;
        logic [ROW_W-1:0]   row;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    // xor fold of the value, reduced into the slot range
    function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] v);
        logic [NCHUNK*SLOT_W-1:0] ext;
        logic [SLOT_W-1:0]        f;
        ext = (NCHUNK*SLOT_W)'(v);
        f   = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            f = f ^ ext[i*SLOT_W +: SLOT_W];
        end
        if ({1'b0, f} >= (SLOT_W+1)'(TABLE_SLOTS)) begin
            f = f - SLOT_W'(TABLE_SLOTS);
        end
        return f;
    endfunction

endpackage

// ===== hdl/stable_unique_key_indexer.sv =====
`timescale 1ns / 1ps
// Assigns each key the dense row of its first appearance in the current batch, using an
// open-addressed hash table with linear probing held in one slot RAM (one read port and
// one write port, registered read). One item at a time: an accepted item passes through
// the start, probe and done states before its result is loaded into the output register,
// and the next item is accepted only after that, back in idle; the done state holds while
// the output register is full and not taken. The probe loop reads one slot per cycle
// through the RAM read port. A new item is accepted while the previous result waits in
// the output register. After reset the block runs a clearing pass over all TABLE_SLOTS
// slots (2048) before it accepts its first item; batches are retired by an 8-bit epoch
// tag, so every 255th batch start repeats that pass before the item is handled.
// Configuration writes are taken in any cycle.
module stable_unique_key_indexer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_key_includes_time,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_start_batch,
    input  logic [63:0]                  i_key_value,
    input  logic [63:0]                  i_key_time,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sukx_pkg::ROW_W-1:0]   o_row_index,
    output logic [1:0]                   o_status
);

    import sukx_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_START = 5'b00100,
        S_LOOK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_pend, n_pend;
    logic [SLOT_W-1:0]    r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [RCNT_W-1:0]    r_rows, n_rows;
    logic                 r_mode, n_mode;
    logic                 r_out_valid, n_out_valid;

    logic [63:0]          r_key_value, n_key_value;
    logic [63:0]          r_key_time, n_key_time;
    logic [SLOT_W-1:0]    r_pos, n_pos;
    logic [SLOT_W-1:0]    r_cnt, n_cnt;
    logic [ROW_W-1:0]     r_res_row, n_res_row;
    t_status              r_res_status, n_res_status;
    logic [ROW_W-1:0]     r_out_row, n_out_row;
    t_status              r_out_status, n_out_status;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_slot                ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SLOT_BITS-1:0] ram_rdata;

    t_slot                rd;
    logic                 slot_used;
    logic                 key_hit;
    logic [SLOT_W-1:0]    pos_inc;
    logic [RCNT_W+ROW_W-1:0] rows_ext;
    logic [ROW_W-1:0]     row_now;

    sukx_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd        = t_slot'(ram_rdata);
    assign slot_used = (rd.tag == r_epoch);
    assign key_hit   = (rd.value == r_key_value) && (!r_mode || rd.time_stamp == r_key_time);
    assign pos_inc   = (r_pos == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : r_pos + SLOT_W'(1);
    assign rows_ext  = {{ROW_W{1'b0}}, r_rows};
    assign row_now   = rows_ext[ROW_W-1:0];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_row_index = r_out_row;
    assign o_status    = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_clr_addr   = r_clr_addr;
        n_epoch      = r_epoch;
        n_rows       = r_rows;
        n_mode       = r_mode;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_key_value  = r_key_value;
        n_key_time   = r_key_time;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_res_row    = r_res_row;
        n_res_status = r_res_status;
        n_out_row    = r_out_row;
        n_out_status = r_out_status;

        ram_we           = 1'b0;
        ram_waddr        = r_pos;
        ram_wdata.tag    = r_epoch;
        ram_wdata.value  = r_key_value;
        ram_wdata.time_stamp = r_key_time;
        ram_wdata.row    = row_now;
        ram_raddr        = r_pos;

        if (i_cfg_valid) begin
            n_mode = i_cfg_key_includes_time;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_clr_addr = '0;
                    n_epoch    = EPOCH_W'(1);
                    n_state    = r_pend ? S_START : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pend      = 1'b1;
                    n_key_value = i_key_value;
                    n_key_time  = i_key_time;
                    n_pos       = home_slot(i_key_value);
                    n_cnt       = '0;
                    n_state     = S_START;
                    if (i_start_batch) begin
                        n_rows = '0;
                        if (r_epoch == {EPOCH_W{1'b1}}) begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end
                end
            end
            S_START: begin
                ram_raddr = r_pos;
                n_state   = S_LOOK;
            end
            S_LOOK: begin
                ram_raddr = pos_inc;
                if (!slot_used) begin
                    n_state = S_DONE;
                    if (r_rows >= RCNT_W'(MAX_ROWS)) begin
                        n_res_row    = '0;
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_pos;
                        n_res_row    = row_now;
                        n_res_status = ST_NEW;
                        n_rows       = r_rows + RCNT_W'(1);
                    end
                end else if (key_hit) begin
                    n_state      = S_DONE;
                    n_res_row    = rd.row;
                    n_res_status = ST_SEEN;
                end else if (r_cnt == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state      = S_DONE;
                    n_res_row    = '0;
                    n_res_status = ST_FULL;
                end else begin
                    n_pos = pos_inc;
                    n_cnt = r_cnt + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_res_row;
                    n_out_status = r_res_status;
                    n_pend       = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pend      <= 1'b0;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_rows      <= '0;
            r_mode      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_rows      <= n_rows;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_value  <= n_key_value;
        r_key_time   <= n_key_time;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_res_row    <= n_res_row;
        r_res_status <= n_res_status;
        r_out_row    <= n_out_row;
        r_out_status <= n_out_status;
    end

`ifndef ASSERT_OFF
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= RCNT_W'(MAX_ROWS))
        else $error("row count above capacity");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START || r_state == S_LOOK) |-> r_epoch != '0)
        else $error("probe with retired epoch");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_START || r_state == S_CLEAR))
        else $error("accepted item not taken to probe");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && ram_we) |=>
            (r_rows == $past(r_rows) + RCNT_W'(1) && r_res_status == ST_NEW))
        else $error("insert without row count step");

    a_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> r_out_row == '0)
        else $error("full status with nonzero row");
`endif

endmodule

// ===== hdl/sukx_ram.sv =====
`timescale 1ns / 1ps
module sukx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import sukx_pkg::*;

    localparam logic [63:0] KEY_STRIDE  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] VALUE_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VALUE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VALUE_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_ITEMS = 200;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        t_status          status;
    } t_row_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_key_includes_time;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_start_batch;
    logic [63:0] i_key_value;
    logic [63:0] i_key_time;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [ROW_W-1:0] o_row_index;
    logic [1:0]  o_status;

    // copy of the block state: keys in order of first appearance
    bit          time_keyed = 1'b1;
    int          rows_used  = 0;
    logic [63:0] row_value [MAX_ROWS];
    logic [63:0] row_stamp [MAX_ROWS];

    t_row_result awaited_rows[$];
    bit          no_stall     = 1'b0;
    int          error_count  = 0;
    int          items_sent   = 0;
    int          rows_checked = 0;
    int          batch_starts = 0;
    int          mode_writes  = 0;
    int          new_count    = 0;
    int          seen_count   = 0;
    int          full_count   = 0;

    stable_unique_key_indexer u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_key_includes_time (i_cfg_key_includes_time),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_start_batch           (i_start_batch),
        .i_key_value             (i_key_value),
        .i_key_time              (i_key_time),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_row_index             (o_row_index),
        .o_status                (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(80_000_000);
        $display("timeout with %0d rows still awaited", awaited_rows.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void index_key(input bit start, input logic [63:0] v,
                                      input logic [63:0] t, output t_row_result res);
        int hit;
        hit = -1;
        if (start) begin
            rows_used = 0;
            batch_starts++;
        end
        for (int r = 0; r < rows_used && hit < 0; r++) begin
            if (row_value[r] == v && (!time_keyed || row_stamp[r] == t)) begin
                hit = r;
            end
        end
        if (hit >= 0) begin
            res.row    = ROW_W'(hit);
            res.status = ST_SEEN;
            seen_count++;
        end else if (rows_used >= MAX_ROWS || rows_used >= TABLE_SLOTS) begin
            res.row    = '0;
            res.status = ST_FULL;
            full_count++;
        end else begin
            row_value[rows_used] = v;
            row_stamp[rows_used] = t;
            res.row    = ROW_W'(rows_used);
            res.status = ST_NEW;
            rows_used++;
            new_count++;
        end
    endfunction

    function automatic logic [63:0] fold_twin(input logic [63:0] v, input int unsigned m);
        logic [63:0] mask;
        mask = 64'(m) & ((64'd1 << SLOT_W) - 1);
        return v ^ mask ^ (mask << SLOT_W);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic note_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_stall || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        t_row_result exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_rows.size() == 0) begin
                note_mismatch($sformatf("unexpected result row %0d status %0d",
                                        o_row_index, o_status));
            end else begin
                exp = awaited_rows.pop_front();
                rows_checked++;
                if (o_row_index !== exp.row) begin
                    note_mismatch($sformatf("result %0d: row %0d, wanted %0d",
                                            rows_checked, o_row_index, exp.row));
                end
                if (o_status !== exp.status) begin
                    note_mismatch($sformatf("result %0d: status %0d, wanted %0d",
                                            rows_checked, o_status, exp.status));
                end
            end
        end
    end

    // returns at the accepting edge with valid still high
    task automatic send_key(input bit start, input logic [63:0] v, input logic [63:0] t);
        t_row_result res;
        @(negedge i_clk);
        if (!no_stall && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_start_batch <= start;
        i_key_value   <= v;
        i_key_time    <= t;
        do @(posedge i_clk); while (!o_in_ready);
        index_key(start, v, t, res);
        awaited_rows = {awaited_rows, res};
        items_sent++;
    endtask

    task automatic settle_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_rows.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit keyed);
        settle_results();
        @(negedge i_clk);
        i_cfg_valid             <= 1'b1;
        i_cfg_key_includes_time <= keyed;
        do @(posedge i_clk); while (!o_cfg_ready);
        time_keyed = keyed;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // runs in the mode left by reset, with the field extremes
    task automatic test_reset_mode();
        send_key(1'b1, 64'd0, 64'd0);
        send_key(1'b0, 64'd0, 64'd0);
        send_key(1'b0, 64'd0, VALUE_ONES);
        send_key(1'b0, VALUE_ONES, 64'd0);
        send_key(1'b0, VALUE_MIN, VALUE_MAX);
        send_key(1'b0, VALUE_MAX, VALUE_MIN);
        send_key(1'b0, VALUE_MAX, VALUE_MIN);
        send_key(1'b0, 64'd0, VALUE_ONES);
    endtask

    // a value stored under several stamps, then matched by value alone
    task automatic test_mode_switch();
        logic [63:0] v1, v2;
        v1 = rand64();
        v2 = ~v1;
        write_mode(1'b1);
        send_key(1'b1, v1, 64'd11);
        send_key(1'b0, v1, 64'd22);
        write_mode(1'b0);
        send_key(1'b0, v1, 64'd33);
        send_key(1'b0, v2, 64'd11);
        send_key(1'b0, v2, 64'd99);
        write_mode(1'b1);
        send_key(1'b0, v1, 64'd22);
        send_key(1'b0, v1, 64'd33);
        send_key(1'b0, v2, 64'd99);
    endtask

    // values sharing one home slot build a long probe chain
    task automatic test_probe_chains();
        logic [63:0] chain [6];
        logic [63:0] t;
        t = rand64();
        chain[0] = rand64();
        for (int k = 1; k < 6; k++) chain[k] = fold_twin(chain[0], k * 37);
        for (int k = 0; k < 6; k++) send_key(k == 0, chain[k], t);
        for (int k = 5; k >= 0; k--) send_key(1'b0, chain[k], t);
        send_key(1'b0, fold_twin(chain[0], 1000), t);
    endtask

    task automatic test_capacity();
        logic [63:0] base, t0;
        base = rand64();
        t0   = rand64();
        write_mode(1'b0);
        send_key(1'b1, base, t0);
        for (int i = 1; i < MAX_ROWS + 8; i++) begin
            send_key(1'b0, base + 64'(i) * KEY_STRIDE, rand64());
        end
        for (int i = 0; i < 16; i++) begin
            send_key(1'b0, base + 64'($urandom_range(MAX_ROWS + 7)) * KEY_STRIDE, rand64());
        end
        write_mode(1'b1);
        send_key(1'b0, base, t0);
        send_key(1'b0, base, ~t0);
        send_key(1'b0, base + 64'(MAX_ROWS + 100) * KEY_STRIDE, t0);
        send_key(1'b1, base, ~t0);
        send_key(1'b0, base, t0);
    endtask

    // many short batches over a small key set, past the batch tag wrap
    task automatic test_epoch_wrap();
        logic [63:0] vals [4];
        logic [63:0] stamps [2];
        int n;
        for (int k = 0; k < 4; k++) vals[k] = rand64();
        stamps[0] = rand64();
        stamps[1] = rand64();
        for (int b = 0; b < 260; b++) begin
            if (b % 60 == 30) begin
                write_mode(!time_keyed);
            end
            n = ($urandom_range(3) == 0) ? 2 : 1;
            for (int k = 0; k < n; k++) begin
                send_key(k == 0, vals[$urandom_range(3)], stamps[$urandom_range(1)]);
            end
        end
    endtask

    task automatic test_random_batches();
        logic [63:0] pool_v [8];
        logic [63:0] pool_t [4];
        logic [63:0] v, t;
        int sent, len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                write_mode(1'($urandom_range(1)));
            end else if ($urandom_range(9) == 0) begin
                settle_results();
            end
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(7))
                    0:       pool_v[k] = VALUE_MIN;
                    1:       pool_v[k] = VALUE_MAX;
                    2:       pool_v[k] = VALUE_ONES;
                    default: pool_v[k] = rand64();
                endcase
                pool_v[k + 4] = fold_twin(pool_v[k], $urandom_range(1, (1 << SLOT_W) - 1));
                pool_t[k]     = ($urandom_range(7) == 0) ? 64'd0 : rand64();
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                no_stall = (sent >= 40 && sent < 160);
                v = ($urandom_range(99) < 70) ? pool_v[$urandom_range(7)] : rand64();
                t = ($urandom_range(99) < 75) ? pool_t[$urandom_range(3)] : rand64();
                if (k > 0 && $urandom_range(59) == 0) begin
                    write_mode(1'($urandom_range(1)));
                end
                send_key(k == 0, v, t);
                sent++;
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_valid             = 1'b0;
        i_cfg_key_includes_time = 1'b1;
        i_in_valid              = 1'b0;
        i_start_batch           = 1'b0;
        i_key_value             = '0;
        i_key_time              = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_mode();
        test_mode_switch();
        test_probe_chains();
        test_capacity();
        test_epoch_wrap();
        test_random_batches();
        write_mode(1'b0);
        send_key(1'b1, VALUE_MIN, VALUE_MAX);
        send_key(1'b0, VALUE_MIN, 64'd0);

        settle_results();
        repeat (64) @(posedge i_clk);
        $display("checked %0d results from %0d items over %0d batches, %0d mode writes",
                 rows_checked, items_sent, batch_starts, mode_writes);
        $display("new keys %0d, repeated keys %0d, rejected by full table %0d",
                 new_count, seen_count, full_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sukx_pkg.sv
hdl/sukx_ram.sv
hdl/stable_unique_key_indexer.sv
verif/testbench.sv
